/* rtl/lmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, command codes and constants of the LED matrix frame driver.
// ----------------------------------------------------------------------------
package lmd_pkg;

	localparam int LMD_COLUMNS = 32;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_REFRESH = 3'd1,
		KIND_INIT    = 3'd2,
		KIND_BRIGHT  = 3'd3,
		KIND_RAW     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_REFRESH,
		OP_INIT,
		OP_CMD
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_LOAD,
		ST_EMIT
	} st_t;

	typedef struct packed {
		op_t         op;
		logic [4:0]  column;
		logic [7:0]  pixels;
		logic [11:0] cmd;
	} lmd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lmd_qstat_t;

	localparam logic [11:0] CMD_WRITE       = 12'h280;
	localparam logic [11:0] CMD_START_SYS   = 12'h802;
	localparam logic [11:0] CMD_LED_ON      = 12'h806;
	localparam logic [11:0] CMD_SET_CLOCK   = 12'h830;
	localparam logic [11:0] CMD_SET_LAYOUT  = 12'h840;
	localparam logic [11:0] CMD_BRIGHT_BASE = 12'h940;
	localparam logic [11:0] CMD_BLINK_OFF   = 12'h810;
	localparam logic [11:0] INIT_BRIGHT     = 12'h8 << 1;

	localparam logic [3:0] BITS_ROW = 4'd8;
	localparam logic [3:0] BITS_HDR = 4'd10;
	localparam logic [3:0] BITS_CMD = 4'd12;

	localparam logic [2:0] INIT_LAST = 3'd5;
	localparam logic [1:0] MAT_LAST  = 2'd3;
	localparam logic [2:0] ROW_LAST  = 3'd7;

	function automatic logic [11:0] init_word(input logic [2:0] idx);
		logic [11:0] w;
		unique case (idx)
			3'd0:    w = CMD_START_SYS;
			3'd1:    w = CMD_LED_ON;
			3'd2:    w = CMD_SET_CLOCK;
			3'd3:    w = CMD_SET_LAYOUT;
			3'd4:    w = CMD_BRIGHT_BASE + INIT_BRIGHT;
			default: w = CMD_BLINK_OFF;
		endcase
		return w;
	endfunction

endpackage

/* rtl/led_matrix_serial_frame_driver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_serial_frame_driver_core
// Frame buffer for four 8x8 LED matrices with serial command word output.
// ----------------------------------------------------------------------------
// An accepted item enters the queue; the sequencer takes it from the head and
// registers its first result in the output register; a column write is stored
// in the frame buffer when taken. Init sends six command words; refresh sends
// a header, then per matrix frame buffer reads fill the transpose tile and eight
// row bytes follow. New items are accepted while the two-entry queue is not full.
// Reset: arst_n clears control state and the per-column valid bits, so the
// frame buffer reads as all zero after reset.
// ----------------------------------------------------------------------------
module led_matrix_serial_frame_driver_core
	import lmd_pkg::*;
#(
	parameter int COLUMNS = LMD_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  column,
	input  logic [7:0]  pixels,
	input  logic [3:0]  level,
	input  logic [11:0] raw_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] shift_word,
	output logic [3:0]  bit_count,
	output logic        strobe_fall,
	output logic        strobe_rise,
	output logic        last
);

	lmd_qstat_t qstat;
	lmd_entry_t push_entry, head;
	logic       push, pop;

	lmd_front #(
		.COLUMNS (COLUMNS)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.column   (column),
		.pixels   (pixels),
		.level    (level),
		.raw_word (raw_word),
		.qstat    (qstat),
		.push     (push),
		.entry    (push_entry)
	);

	lmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	lmd_back #(
		.COLUMNS (COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.shift_word  (shift_word),
		.bit_count   (bit_count),
		.strobe_fall (strobe_fall),
		.strobe_rise (strobe_rise),
		.last        (last)
	);

endmodule

/* rtl/lmd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lmd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_front
// Input side: takes items, drops unknown kinds and out-of-range column
// writes, and turns the rest into queue entries.
// ----------------------------------------------------------------------------
module lmd_front
	import lmd_pkg::*;
#(
	parameter int COLUMNS = LMD_COLUMNS
) (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  column,
	input  logic [7:0]  pixels,
	input  logic [3:0]  level,
	input  logic [11:0] raw_word,
	input  lmd_qstat_t  qstat,
	output logic        push,
	output lmd_entry_t  entry
);

	logic keep;

	always_comb begin
		keep         = 1'b0;
		entry.op     = OP_CMD;
		entry.column = column;
		entry.pixels = pixels;
		entry.cmd    = raw_word;
		unique case (kind)
			KIND_WRITE: begin
				entry.op = OP_WRITE;
				keep     = 7'(column) < 7'(COLUMNS);
			end
			KIND_REFRESH: begin
				entry.op = OP_REFRESH;
				keep     = 1'b1;
			end
			KIND_INIT: begin
				entry.op = OP_INIT;
				keep     = 1'b1;
			end
			KIND_BRIGHT: begin
				entry.cmd = CMD_BRIGHT_BASE + 12'({level, 1'b0});
				keep      = 1'b1;
			end
			KIND_RAW: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full && keep;

endmodule

/* rtl/lmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_queue
// Two-entry queue between the input classifier and the output sequencer.
// ----------------------------------------------------------------------------
module lmd_queue
	import lmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lmd_entry_t push_entry,
	input  logic       pop,
	output lmd_entry_t head,
	output lmd_qstat_t qstat
);

	lmd_entry_t ents_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ents_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head        = ents_q[rd_ptr_q];
	assign qstat.full  = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

/* rtl/lmd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_back
// Output sequencer: frame buffer writes, command words, and the refresh
// transpose (eight column reads into a tile, then eight row bytes).
// ----------------------------------------------------------------------------
module lmd_back
	import lmd_pkg::*;
#(
	parameter int COLUMNS = LMD_COLUMNS,
	localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lmd_qstat_t  qstat,
	input  lmd_entry_t  head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] shift_word,
	output logic [3:0]  bit_count,
	output logic        strobe_fall,
	output logic        strobe_rise,
	output logic        last
);

	st_t          st_q, st_d;
	logic [2:0]   idx_q, idx_d;
	logic [1:0]   m_q, m_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [2:0]   row_q, row_d;
	logic [7:0]   tile_q [8];
	logic [COLUMNS-1:0] vld_q;
	logic         rvld_s1;

	logic         out_valid_q;
	logic [11:0]  word_q;
	logic [3:0]   bits_q;
	logic         fall_q, rise_q, last_q;

	logic         can_load, ld;
	logic [11:0]  ld_word;
	logic [3:0]   ld_bits;
	logic         ld_fall, ld_rise, ld_last;
	logic         ram_we, ram_re;
	logic [7:0]   wcol, rcol;
	logic [AW-1:0] waddr, raddr;
	logic         rd_in_range;
	logic [7:0]   rdata, rbyte, row_byte;

	assign wcol        = 8'(head.column);
	assign waddr       = wcol[AW-1:0];
	assign rcol        = 8'({m_q, cnt_q[2:0]});
	assign raddr       = rcol[AW-1:0];
	assign rd_in_range = rcol < 8'(COLUMNS);
	assign rbyte       = rdata & {8{rvld_s1}};

	lmd_ram #(
		.WIDTH (8),
		.DEPTH (COLUMNS)
	) u_fb (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (head.pixels),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			row_byte[7-c] = tile_q[c][row_q];
		end
	end

	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		st_d    = st_q;
		idx_d   = idx_q;
		m_d     = m_q;
		cnt_d   = cnt_q;
		row_d   = row_q;
		pop     = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		ld      = 1'b0;
		ld_word = CMD_WRITE;
		ld_bits = BITS_CMD;
		ld_fall = 1'b1;
		ld_rise = 1'b1;
		ld_last = 1'b1;
		unique case (st_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					unique case (head.op)
						OP_WRITE: begin
							ram_we = 1'b1;
							pop    = 1'b1;
						end
						OP_CMD: begin
							if (can_load) begin
								ld      = 1'b1;
								ld_word = head.cmd;
								pop     = 1'b1;
							end
						end
						OP_INIT: begin
							if (can_load) begin
								ld      = 1'b1;
								ld_word = init_word(3'd0);
								ld_last = 1'b0;
								pop     = 1'b1;
								idx_d   = 3'd1;
								st_d    = ST_INIT;
							end
						end
						OP_REFRESH: begin
							if (can_load) begin
								ld      = 1'b1;
								ld_word = CMD_WRITE;
								ld_bits = BITS_HDR;
								ld_rise = 1'b0;
								ld_last = 1'b0;
								pop     = 1'b1;
								m_d     = 2'd0;
								cnt_d   = 4'd0;
								st_d    = ST_LOAD;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_INIT: begin
				if (can_load) begin
					ld      = 1'b1;
					ld_word = init_word(idx_q);
					ld_last = idx_q == INIT_LAST;
					idx_d   = idx_q + 3'd1;
					if (idx_q == INIT_LAST) begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_LOAD: begin
				ram_re = !cnt_q[3];
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q[3]) begin
					row_d = 3'd0;
					st_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (can_load) begin
					ld      = 1'b1;
					ld_word = 12'(row_byte);
					ld_bits = BITS_ROW;
					ld_fall = 1'b0;
					ld_rise = (m_q == MAT_LAST) && (row_q == ROW_LAST);
					ld_last = (m_q == MAT_LAST) && (row_q == ROW_LAST);
					row_d   = row_q + 3'd1;
					if (row_q == ROW_LAST) begin
						if (m_q == MAT_LAST) begin
							st_d = ST_IDLE;
						end else begin
							m_d   = m_q + 2'd1;
							cnt_d = 4'd0;
							st_d  = ST_LOAD;
						end
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= 3'd0;
			m_q         <= 2'd0;
			cnt_q       <= 4'd0;
			row_q       <= 3'd0;
			vld_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			idx_q   <= idx_d;
			m_q     <= m_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
			rvld_s1 <= ram_re && rd_in_range && vld_q[raddr];
			if (ram_we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && cnt_q != 4'd0) begin
			tile_q[3'(cnt_q - 4'd1)] <= rbyte;
		end
		if (ld) begin
			word_q <= ld_word;
			bits_q <= ld_bits;
			fall_q <= ld_fall;
			rise_q <= ld_rise;
			last_q <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign shift_word  = word_q;
	assign bit_count   = bits_q;
	assign strobe_fall = fall_q;
	assign strobe_rise = rise_q;
	assign last        = last_q;

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> st_q == ST_IDLE)
		else $error("frame buffer write outside idle");

	a_header_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bits_q == BITS_HDR |-> fall_q && !rise_q && !last_q)
		else $error("refresh header framing wrong");

	a_row_rise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bits_q == BITS_ROW |-> !fall_q && rise_q == last_q)
		else $error("row byte framing wrong");

endmodule
